// ----- rtl/core/ntt_radix2_transform_assert.svh -----
// assertion macros used by the checker file
`ifndef NTT_RADIX2_TRANSFORM_ASSERT_SVH
`define NTT_RADIX2_TRANSFORM_ASSERT_SVH

// same-cycle implication, masked during reset
`define NTT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ntt assertion failed");

// next-cycle implication, masked during reset
`define NTT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ntt assertion failed");

// next-cycle implication, also checked across reset
`define NTT_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ntt assertion failed");

`endif

// ----- rtl/core/ntt_pkg.sv -----
// ----------------------------------------------------------------------------
// ntt_pkg
// types, constants and helper functions of the radix-2 ntt block
// ----------------------------------------------------------------------------
package ntt_pkg;

  localparam int MAX_LOG  = 6;
  localparam int MAX_SIZE = 64;
  localparam int COEFF_W  = 30;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;

  localparam logic [COEFF_W-1:0] PRIME = 30'd1004535809;
  localparam longint unsigned    ROOT  = 64'd3;

  localparam logic [2:0] DEF_LOG = 3'd6;

  // register indexes on the configuration port
  localparam logic REG_LOG_SIZE = 1'b0;
  localparam logic REG_INVERSE  = 1'b1;

  typedef logic [COEFF_W-1:0] coeff_t;
  typedef coeff_t twid_tab_t [MAX_SIZE];

  // one queued input transaction
  typedef struct packed {
    coeff_t           coeff;
    logic [IDX_W-1:0] addr;
    logic             store;
    logic             last;
  } ntt_item_t;

  // request to the shared modular multiplier
  typedef struct packed {
    logic   start;
    coeff_t a;
    coeff_t b;
  } mul_req_t;

  // clamp the configured length exponent
  function automatic logic [2:0] eff_log(input logic [2:0] lg);
    logic [2:0] r;
    if (lg == 3'd0) r = 3'd1;
    else if (lg > 3'(MAX_LOG)) r = 3'(MAX_LOG);
    else r = lg;
    return r;
  endfunction

  // inverse of 2^lg modulo the prime
  function automatic coeff_t inv_size(input logic [2:0] lg);
    coeff_t r;
    case (lg)
      3'd1:    r = 30'd502267905;
      3'd2:    r = 30'd753401857;
      3'd3:    r = 30'd878968833;
      3'd4:    r = 30'd941752321;
      3'd5:    r = 30'd973144065;
      3'd6:    r = 30'd988839937;
      default: r = '0;
    endcase
    return r;
  endfunction

  // shift-and-add product modulo the prime, for reduced operands
  function automatic longint unsigned mul_mod_p(input longint unsigned x,
                                                input longint unsigned y);
    longint unsigned p;
    longint unsigned r;
    int              k;
    p = longint'(PRIME);
    r = 0;
    for (k = COEFF_W - 1; k >= 0; k--) begin
      r = r << 1;
      if (r >= p) r = r - p;
      if (y[k]) begin
        r = r + x;
        if (r >= p) r = r - p;
      end
    end
    return r;
  endfunction

  // twiddle table, entry len+j holds wn^j, evaluated at elaboration
  function automatic twid_tab_t twiddle_table();
    twid_tab_t        t;
    longint unsigned  e;
    longint unsigned  base;
    longint unsigned  wn;
    longint unsigned  w;
    int               l;
    int               j;
    for (j = 0; j < MAX_SIZE; j++) t[j] = '0;
    for (l = 0; l < MAX_LOG; l++) begin
      e    = (longint'(PRIME) - 1) >> (l + 1);
      base = ROOT;
      wn   = 1;
      while (e != 0) begin
        if (e[0]) wn = mul_mod_p(wn, base);
        base = mul_mod_p(base, base);
        e    = e >> 1;
      end
      w = 1;
      for (j = 0; j < (1 << l); j++) begin
        t[(1 << l) + j] = COEFF_W'(w);
        w = mul_mod_p(w, wn);
      end
    end
    return t;
  endfunction

  localparam twid_tab_t TWIDDLE = twiddle_table();

  // modular add and subtract of reduced residues
  function automatic coeff_t mod_add(input coeff_t x, input coeff_t y);
    logic [COEFF_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, PRIME}) s = s - {1'b0, PRIME};
    return s[COEFF_W-1:0];
  endfunction

  function automatic coeff_t mod_sub(input coeff_t x, input coeff_t y);
    logic [COEFF_W:0] s;
    if (x >= y) s = {1'b0, x} - {1'b0, y};
    else s = {1'b0, x} + {1'b0, PRIME} - {1'b0, y};
    return s[COEFF_W-1:0];
  endfunction

endpackage

// ----- rtl/core/ntt_if.sv -----
// ----------------------------------------------------------------------------
// ntt_in_if / ntt_out_if
// valid/ready channels for coefficients and transform results
// ----------------------------------------------------------------------------
interface ntt_in_if import ntt_pkg::*;;
  logic   valid;
  logic   ready;
  coeff_t coeff;
  logic   last_in;

  modport source (output valid, coeff, last_in, input ready);
  modport sink   (input valid, coeff, last_in, output ready);
endinterface

interface ntt_out_if import ntt_pkg::*;;
  logic             valid;
  logic             ready;
  coeff_t           value;
  logic [IDX_W-1:0] index;
  logic             last_out;

  modport source (output valid, value, index, last_out, input ready);
  modport sink   (input valid, value, index, last_out, output ready);
endinterface

// ----- rtl/core/ntt_front.sv -----
// ----------------------------------------------------------------------------
// ntt_front
// accepts coefficients, reduces them and tags each with its store slot
// ----------------------------------------------------------------------------
module ntt_front import ntt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  log_size,
  ntt_in_if.sink      in_if,
  input  logic        q_full,
  output logic        q_push,
  output ntt_item_t   q_item
);

  logic [CNT_W-1:0] load_cnt_r;
  logic [CNT_W-1:0] size;
  logic [COEFF_W:0] diff;
  logic             store;

  assign size   = CNT_W'(1) << eff_log(log_size);
  assign store  = load_cnt_r < size;
  assign diff   = {1'b0, in_if.coeff} - {1'b0, PRIME};

  // input stalls only on a full queue
  assign in_if.ready = !q_full;
  assign q_push      = in_if.valid && !q_full;

  // one compare-subtract reduces any 30-bit value
  always_comb begin
    q_item.coeff = diff[COEFF_W] ? in_if.coeff : diff[COEFF_W-1:0];
    q_item.addr  = load_cnt_r[IDX_W-1:0];
    q_item.store = store;
    q_item.last  = in_if.last_in;
  end

  // load counter, restarts after each last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
    end else if (q_push) begin
      if (in_if.last_in) load_cnt_r <= '0;
      else if (store) load_cnt_r <= load_cnt_r + CNT_W'(1);
    end
  end

endmodule

// ----- rtl/core/ntt_queue.sv -----
// ----------------------------------------------------------------------------
// ntt_queue
// small fifo decoupling the front from the transform engine
// ----------------------------------------------------------------------------
module ntt_queue import ntt_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ntt_item_t push_item,
  input  logic      pop,
  output ntt_item_t head,
  output logic      empty,
  output logic      full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ntt_item_t       slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign empty = count_r == '0;
  assign full  = count_r == CW'(DEPTH);
  assign head  = slot_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      if (push && !pop) count_r <= count_r + CW'(1);
      else if (pop && !push) count_r <= count_r - CW'(1);
    end
  end

endmodule

// ----- rtl/core/ntt_mul.sv -----
// ----------------------------------------------------------------------------
// ntt_mul
// bit-serial modular multiplier, one bit of a per cycle
// ----------------------------------------------------------------------------
module ntt_mul import ntt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output logic     done,
  output coeff_t   result
);

  coeff_t          a_r;
  coeff_t          b_r;
  coeff_t          acc_r;
  logic [4:0]      bit_r;
  logic            busy_r;
  logic            done_r;
  logic [31:0]     t;
  coeff_t          acc_nxt;

  // double, add, then reduce below the prime
  always_comb begin
    t = {1'b0, acc_r, 1'b0} + (a_r[bit_r] ? {2'b00, b_r} : 32'd0);
    if (t >= {1'b0, PRIME, 1'b0}) acc_nxt = COEFF_W'(t - {1'b0, PRIME, 1'b0});
    else if (t >= {2'b00, PRIME}) acc_nxt = COEFF_W'(t - {2'b00, PRIME});
    else acc_nxt = t[COEFF_W-1:0];
  end

  assign done   = done_r;
  assign result = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        a_r    <= req.a;
        b_r    <= req.b;
        acc_r  <= '0;
        bit_r  <= 5'(COEFF_W - 1);
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        bit_r <= bit_r - 5'd1;
        if (bit_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/ntt_back.sv -----
// ----------------------------------------------------------------------------
// ntt_back
// stores coefficients, runs the butterfly stages and emits the results
// ----------------------------------------------------------------------------
module ntt_back import ntt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [2:0] log_size,
  input  logic       inverse_mode,
  input  ntt_item_t  q_head,
  input  logic       q_empty,
  output logic       q_pop,
  ntt_out_if.source  out_if
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_CP_RD   = 4'd1;
  localparam logic [3:0] ST_CP_WR   = 4'd2;
  localparam logic [3:0] ST_BF_RD   = 4'd3;
  localparam logic [3:0] ST_BF_LD   = 4'd4;
  localparam logic [3:0] ST_BF_MUL  = 4'd5;
  localparam logic [3:0] ST_BF_WB   = 4'd6;
  localparam logic [3:0] ST_OUT_RD  = 4'd7;
  localparam logic [3:0] ST_OUT_LD  = 4'd8;
  localparam logic [3:0] ST_OUT_MUL = 4'd9;
  localparam logic [3:0] ST_OUT_TX  = 4'd10;

  logic [3:0]          state_r;
  coeff_t              cst_mem [MAX_SIZE];
  coeff_t              wrk_mem [MAX_SIZE];
  logic [MAX_SIZE-1:0] vld_r;
  coeff_t              cst_rd_r;
  coeff_t              rd_a_r;
  coeff_t              rd_b_r;
  logic [IDX_W-1:0]    i_r;
  logic [2:0]          s_r;
  logic [IDX_W-2:0]    k_r;
  coeff_t              x_r;
  coeff_t              diff_r;
  coeff_t              value_r;
  logic [IDX_W-1:0]    index_r;
  logic                last_r;
  logic                out_vld_r;

  logic [2:0]          lg;
  logic [IDX_W-1:0]    size_m1;
  logic [IDX_W-1:0]    len;
  logic [IDX_W-1:0]    len_m1;
  logic [IDX_W-1:0]    kk;
  logic [IDX_W-1:0]    a_addr;
  logic [IDX_W-1:0]    b_addr;
  logic [IDX_W-1:0]    tw_idx;
  logic [IDX_W-1:0]    rev_full;
  logic [IDX_W-1:0]    rev_i;
  logic [IDX_W-1:0]    src_i;
  logic [IDX_W-1:0]    ra;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  coeff_t              wr_data;
  mul_req_t            mreq;
  logic                mdone;
  coeff_t              mres;

  // length and address arithmetic
  always_comb begin
    lg       = eff_log(log_size);
    size_m1  = IDX_W'((CNT_W'(1) << lg) - CNT_W'(1));
    len      = IDX_W'(CNT_W'(1) << s_r);
    len_m1   = len - IDX_W'(1);
    kk       = {1'b0, k_r};
    a_addr   = ((kk & ~len_m1) << 1) | (kk & len_m1);
    b_addr   = a_addr | len;
    tw_idx   = len | (kk & len_m1);
    rev_full = {<<{i_r}};
    rev_i    = rev_full >> (3'(MAX_LOG) - lg);
    src_i    = inverse_mode ? (IDX_W'(0) - i_r) & size_m1 : i_r;
    ra       = (state_r == ST_OUT_RD) ? src_i : a_addr;
  end

  assign q_pop = (state_r == ST_IDLE) && !q_empty;

  // shared multiplier requests
  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = TWIDDLE[tw_idx];
    mreq.b     = rd_b_r;
    if (state_r == ST_BF_LD) begin
      mreq.start = 1'b1;
    end else if (state_r == ST_OUT_LD && inverse_mode) begin
      mreq.start = 1'b1;
      mreq.a     = rd_a_r;
      mreq.b     = inv_size(lg);
    end
  end

  ntt_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mreq),
    .done   (mdone),
    .result (mres)
  );

  // work memory write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rev_i;
    wr_data = vld_r[i_r] ? cst_rd_r : '0;
    if (state_r == ST_CP_WR) begin
      wr_en = 1'b1;
    end else if (state_r == ST_BF_MUL && mdone) begin
      wr_en   = 1'b1;
      wr_addr = a_addr;
      wr_data = mod_add(x_r, mres);
    end else if (state_r == ST_BF_WB) begin
      wr_en   = 1'b1;
      wr_addr = b_addr;
      wr_data = diff_r;
    end
  end

  // coefficient store
  always_ff @(posedge clk) begin
    if (q_pop && q_head.store) cst_mem[q_head.addr] <= q_head.coeff;
    cst_rd_r <= cst_mem[i_r];
  end

  // work memory, one write and two reads
  always_ff @(posedge clk) begin
    if (wr_en) wrk_mem[wr_addr] <= wr_data;
    rd_a_r <= wrk_mem[ra];
    rd_b_r <= wrk_mem[b_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      vld_r     <= '0;
      out_vld_r <= 1'b0;
      i_r       <= '0;
      s_r       <= '0;
      k_r       <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_head.store) vld_r[q_head.addr] <= 1'b1;
            if (q_head.last) begin
              i_r     <= '0;
              state_r <= ST_CP_RD;
            end
          end
        end
        ST_CP_RD: state_r <= ST_CP_WR;
        ST_CP_WR: begin
          if (i_r == size_m1) begin
            s_r     <= '0;
            k_r     <= '0;
            state_r <= ST_BF_RD;
          end else begin
            i_r     <= i_r + IDX_W'(1);
            state_r <= ST_CP_RD;
          end
        end
        ST_BF_RD: state_r <= ST_BF_LD;
        ST_BF_LD: begin
          x_r     <= rd_a_r;
          state_r <= ST_BF_MUL;
        end
        ST_BF_MUL: begin
          if (mdone) begin
            diff_r  <= mod_sub(x_r, mres);
            state_r <= ST_BF_WB;
          end
        end
        ST_BF_WB: begin
          state_r <= ST_BF_RD;
          if (kk == (size_m1 >> 1)) begin
            k_r <= '0;
            if (s_r == lg - 3'd1) begin
              i_r     <= '0;
              state_r <= ST_OUT_RD;
            end else begin
              s_r <= s_r + 3'd1;
            end
          end else begin
            k_r <= k_r + (IDX_W-1)'(1);
          end
        end
        ST_OUT_RD: state_r <= ST_OUT_LD;
        ST_OUT_LD: begin
          index_r <= i_r;
          last_r  <= i_r == size_m1;
          if (inverse_mode) begin
            state_r <= ST_OUT_MUL;
          end else begin
            value_r   <= rd_a_r;
            out_vld_r <= 1'b1;
            state_r   <= ST_OUT_TX;
          end
        end
        ST_OUT_MUL: begin
          if (mdone) begin
            value_r   <= mres;
            out_vld_r <= 1'b1;
            state_r   <= ST_OUT_TX;
          end
        end
        ST_OUT_TX: begin
          if (out_if.ready) begin
            out_vld_r <= 1'b0;
            if (last_r) begin
              vld_r   <= '0;
              state_r <= ST_IDLE;
            end else begin
              i_r     <= i_r + IDX_W'(1);
              state_r <= ST_OUT_RD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_if.valid    = out_vld_r;
  assign out_if.value    = value_r;
  assign out_if.index    = index_r;
  assign out_if.last_out = last_r;

endmodule

// ----- rtl/core/ntt_radix2_transform.sv -----
// Loading: one coefficient per cycle into a small queue while it is not full; the engine
// files one per cycle while idle. Transform after last: a bit-reversed reorder, then butterflies
// on the single bit-serial multiplier, then the results (each multiplied by 1/N in inverse mode).
// Reset: synchronous active-low rst_n clears control, store marks and registers.
// ----------------------------------------------------------------------------
// ntt_radix2_transform
// radix-2 number theoretic transform modulo 1004535809 with apb configuration
// ----------------------------------------------------------------------------
module ntt_radix2_transform import ntt_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  ntt_in_if.sink      in_if,
  ntt_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [2:0] log_size_r;
  logic       inverse_r;
  logic       q_full;
  logic       q_empty;
  logic       q_push;
  logic       q_pop;
  ntt_item_t  q_in;
  ntt_item_t  q_head;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_size_r <= DEF_LOG;
      inverse_r  <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_LOG_SIZE: log_size_r <= pwdata[2:0];
        REG_INVERSE:  inverse_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LOG_SIZE: prdata = {29'd0, log_size_r};
      REG_INVERSE:  prdata = {31'd0, inverse_r};
      default:      prdata = '0;
    endcase
  end

  ntt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .log_size (log_size_r),
    .in_if    (in_if),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  ntt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  ntt_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .log_size     (log_size_r),
    .inverse_mode (inverse_r),
    .q_head       (q_head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_if       (out_if)
  );

endmodule

// ----- rtl/core/ntt_checker.sv -----
// ----------------------------------------------------------------------------
// ntt_checker
// port-level checks of the result stream, bound to the top level
// ----------------------------------------------------------------------------
`include "ntt_radix2_transform_assert.svh"

module ntt_checker import ntt_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input coeff_t           out_value,
  input logic [IDX_W-1:0] out_index,
  input logic             out_last
);

  logic [IDX_W-1:0] exp_idx_r;

  // expected index of the next result transaction
  always_ff @(posedge clk) begin
    if (!rst_n) exp_idx_r <= '0;
    else if (out_valid && out_ready) exp_idx_r <= out_last ? '0 : exp_idx_r + IDX_W'(1);
  end

  `NTT_ASSERT_IMP(a_value_reduced, out_valid, out_value < PRIME)
  `NTT_ASSERT_IMP(a_index_order, out_valid, out_index == exp_idx_r)
  `NTT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value))
  `NTT_ASSERT_RST(a_reset_quiet, !rst_n, !out_valid)

endmodule

bind ntt_radix2_transform ntt_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_value (out_if.value),
  .out_index (out_if.index),
  .out_last  (out_if.last_out)
);
